### hw/rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, constants and the CRC-16 byte step of the Modbus RTU request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SYNC  = 2'd2
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } seq_state_t;

  typedef logic [3:0] byte_pos_t;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  FUNC_READ      = 8'h03;
  localparam logic [7:0]  FUNC_WRITE     = 8'h06;
  localparam logic [7:0]  FUNC_SYNC      = 8'h10;
  localparam logic [7:0]  SYNC_REG_HI    = 8'h20;
  localparam logic [7:0]  SYNC_REG_LO    = 8'h88;
  localparam logic [7:0]  SYNC_QTY_HI    = 8'h00;
  localparam logic [7:0]  SYNC_QTY_LO    = 8'h02;
  localparam logic [7:0]  SYNC_BYTE_CNT  = 8'h04;
  localparam logic [7:0]  READ_QTY_HI    = 8'h00;
  localparam logic [7:0]  READ_QTY_LO    = 8'h01;
  localparam byte_pos_t   BODY_LEN_SHORT = 4'd6;
  localparam byte_pos_t   BODY_LEN_SYNC  = 4'd11;

  typedef struct packed {
    logic [15:0] value_b;
    logic [15:0] value_a;
    logic [15:0] reg_addr;
    logic [7:0]  slave_id;
    logic [1:0]  action;
  } req_t;

  typedef struct packed {
    logic       init;
    logic       feed;
    logic [7:0] data;
  } crc_ctrl_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/mrf_req_if.sv
// ----------------------------------------------------------------------------
// mrf_req_if
// Request channel: valid/ready handshake with the framing request payload.
// ----------------------------------------------------------------------------
interface mrf_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         slave_id;
  logic [15:0]        reg_addr;
  logic signed [15:0] value_a;
  logic signed [15:0] value_b;

  modport source (output valid, output action, output slave_id, output reg_addr,
                  output value_a, output value_b, input ready);
  modport sink   (input valid, input action, input slave_id, input reg_addr,
                  input value_a, input value_b, output ready);
endinterface

### hw/rtl/mrf_tx_if.sv
// ----------------------------------------------------------------------------
// mrf_tx_if
// Frame byte channel: valid/ready handshake with one byte and an end flag.
// ----------------------------------------------------------------------------
interface mrf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

### hw/rtl/modbus_rtu_request_framer_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_top
// Modbus RTU request framer: one request in, a full frame out byte by byte.
//
//   channel  dir  payload                                      handshake
//   req      in   action, slave_id, reg_addr, value_a, value_b valid/ready
//   tx       out  tx_byte, last_byte                           valid/ready
//
// A read or single-write request yields an 8-byte frame, a two-value write
// a 13-byte frame; after the accept, one byte goes out per cycle while tx
// does not stall, the CRC unit taking one step per body byte. req.ready is high
// only between frames. A request with action 3 is taken and dropped.
// Synchronous reset, active high; a stall on tx holds the output byte
// and pauses the sequence.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_top
  import mrf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  mrf_req_if.sink  req,
  mrf_tx_if.source tx
);

  crc_ctrl_t   crc_ctrl;
  logic [15:0] crc;

  mrf_frame_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .tx       (tx),
    .crc      (crc),
    .crc_ctrl (crc_ctrl)
  );

  mrf_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .crc  (crc)
  );

endmodule

### hw/rtl/mrf_crc_unit.sv
// ----------------------------------------------------------------------------
// mrf_crc_unit
// Shared CRC-16 register, restarted per frame and fed one byte per step.
// ----------------------------------------------------------------------------
module mrf_crc_unit
  import mrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  crc_ctrl_t   ctrl,
  output logic [15:0] crc
);

  logic [15:0] crc_next;

  always_comb begin
    priority if (ctrl.init) begin
      crc_next = CRC_INIT;
    end else if (ctrl.feed) begin
      crc_next = crc_feed(crc, ctrl.data);
    end else begin
      crc_next = crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

### hw/rtl/mrf_frame_seq.sv
// ----------------------------------------------------------------------------
// mrf_frame_seq
// Byte sequencer: holds the request, steps through the frame, drives the CRC
// unit and the output register.
// ----------------------------------------------------------------------------
module mrf_frame_seq
  import mrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mrf_req_if.sink     req,
  mrf_tx_if.source    tx,
  input  logic [15:0] crc,
  output crc_ctrl_t   crc_ctrl
);

  seq_state_t  state, state_next;
  byte_pos_t   pos;
  req_t        held;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  logic        accept;
  logic        act_ok;
  logic        advance;
  byte_pos_t   body_len;
  logic        in_body;
  logic        is_last;
  logic [7:0]  body_byte;
  logic [7:0]  cur_byte;

  assign accept   = req.valid && req.ready;
  assign act_ok   = (req.action == ACT_READ) || (req.action == ACT_WRITE) ||
                    (req.action == ACT_SYNC);
  assign body_len = (held.action == ACT_SYNC) ? BODY_LEN_SYNC : BODY_LEN_SHORT;
  assign in_body  = pos < body_len;
  assign is_last  = pos == (body_len + 4'd1);

  // frame body byte at the current position
  always_comb begin
    body_byte = 8'h00;
    if (held.action == ACT_SYNC) begin
      unique case (pos)
        4'd0:    body_byte = held.slave_id;
        4'd1:    body_byte = FUNC_SYNC;
        4'd2:    body_byte = SYNC_REG_HI;
        4'd3:    body_byte = SYNC_REG_LO;
        4'd4:    body_byte = SYNC_QTY_HI;
        4'd5:    body_byte = SYNC_QTY_LO;
        4'd6:    body_byte = SYNC_BYTE_CNT;
        4'd7:    body_byte = held.value_a[15:8];
        4'd8:    body_byte = held.value_a[7:0];
        4'd9:    body_byte = held.value_b[15:8];
        4'd10:   body_byte = held.value_b[7:0];
        default: body_byte = 8'h00;
      endcase
    end else begin
      unique case (pos)
        4'd0:    body_byte = held.slave_id;
        4'd1:    body_byte = (held.action == ACT_READ) ? FUNC_READ : FUNC_WRITE;
        4'd2:    body_byte = held.reg_addr[15:8];
        4'd3:    body_byte = held.reg_addr[7:0];
        4'd4:    body_byte = (held.action == ACT_READ) ? READ_QTY_HI : held.value_a[15:8];
        4'd5:    body_byte = (held.action == ACT_READ) ? READ_QTY_LO : held.value_a[7:0];
        default: body_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    priority if (in_body) begin
      cur_byte = body_byte;
    end else if (pos == body_len) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = crc[15:8];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && act_ok) state_next = ST_SEND;
      ST_SEND: if (advance && is_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready     = 1'b0;
    advance       = 1'b0;
    unique case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_SEND: advance   = !out_valid || tx.ready;
      default: advance   = 1'b0;
    endcase
    crc_ctrl.init = accept && act_ok;
    crc_ctrl.feed = advance && in_body;
    crc_ctrl.data = cur_byte;
  end

  assign tx.valid     = out_valid;
  assign tx.tx_byte   = out_byte;
  assign tx.last_byte = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pos <= '0;
      end else if (advance) begin
        pos <= is_last ? 4'd0 : pos + 4'd1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept && act_ok) begin
      held <= '{value_b: req.value_b, value_a: req.value_a, reg_addr: req.reg_addr,
                slave_id: req.slave_id, action: req.action};
    end
    if (advance) begin
      out_byte <= cur_byte;
      out_last <= is_last;
    end
  end

endmodule
